// ===== sv/bdips_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce and IR pulse sender: shared definitions
// Widths, register indexes, reset values and the structs passed between the
// button lanes, the burst sequencer and the top level.
// ----------------------------------------------------------------------------
package bdips_pkg;

    localparam int CNT_W  = 8;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MARK_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MARK_TICKS    = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0]  THRESHOLD_RST  = 8'd100;
    localparam logic [TICK_W-1:0] HEADER_RST     = 16'd377;
    localparam logic [TICK_W-1:0] GAP_RST        = 16'd38;
    localparam logic [TICK_W-1:0] SHORT_MARK_RST = 16'd75;
    localparam logic [TICK_W-1:0] LONG_MARK_RST  = 16'd151;

    typedef struct packed {
        logic red;
        logic blue;
        logic yellow;
    } btn_t;

    typedef struct packed {
        logic [TICK_W-1:0] header;
        logic [TICK_W-1:0] gap;
        logic [TICK_W-1:0] short_mark;
        logic [TICK_W-1:0] long_mark;
    } dur_cfg_t;

    typedef struct packed {
        logic laser_en;
        logic ir_enable;
        logic burst_busy;
    } result_t;

endpackage

// ===== sv/bdips_lane.sv =====
// ----------------------------------------------------------------------------
// Button lane
// Saturating debounce counter for one button and its pressed decision.
// ----------------------------------------------------------------------------
module bdips_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic                      raw,
    input  logic [bdips_pkg::CNT_W-1:0] threshold,
    output logic                      pressed
);
    import bdips_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        if (!raw)
        begin
            count_next = '0;
        end
        else if (count_reg < COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // The decision uses the count after this tick's update.
    assign pressed = (count_next > threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step)
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/bdips_seq.sv =====
// ----------------------------------------------------------------------------
// Burst sequencer
// Merges the three lane decisions: edge detection, laser gating and the
// header, gap and mark phases of an IR burst with a pending yellow burst.
// ----------------------------------------------------------------------------
module bdips_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  bdips_pkg::btn_t      pressed,
    input  bdips_pkg::dur_cfg_t  dur,
    output bdips_pkg::result_t   result
);
    import bdips_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_GAP    = 2'd2,
        PH_MARK   = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              long_reg, long_next;
    logic              pending_reg, pending_next;
    logic              prev_blue_reg, prev_blue_next;
    logic              prev_yellow_reg, prev_yellow_next;

    // Phase, count and length after a possible burst start on this tick.
    phase_t            phase_cur;
    logic [TICK_W-1:0] ticks_cur;
    logic              long_cur;
    logic              blue_edge;
    logic              yellow_edge;

    assign blue_edge   = pressed.blue & ~prev_blue_reg;
    assign yellow_edge = pressed.yellow & ~prev_yellow_reg;

    always_comb
    begin
        phase_cur        = phase_reg;
        ticks_cur        = ticks_reg;
        long_cur         = long_reg;
        pending_next     = pending_reg;
        prev_blue_next   = prev_blue_reg;
        prev_yellow_next = prev_yellow_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (pending_reg)
            begin
                // The pending yellow burst goes out before any new sampling.
                pending_next = 1'b0;
                phase_cur    = PH_HEADER;
                ticks_cur    = dur.header;
                long_cur     = 1'b1;
            end
            else
            begin
                prev_blue_next   = pressed.blue;
                prev_yellow_next = pressed.yellow;
                if (blue_edge)
                begin
                    pending_next = yellow_edge;
                    phase_cur    = PH_HEADER;
                    ticks_cur    = dur.header;
                    long_cur     = 1'b0;
                end
                else if (yellow_edge)
                begin
                    phase_cur = PH_HEADER;
                    ticks_cur = dur.header;
                    long_cur  = 1'b1;
                end
            end
        end

        result.laser_en   = (phase_cur == PH_IDLE) & pressed.red;
        result.ir_enable  = (phase_cur == PH_HEADER) | (phase_cur == PH_MARK);
        result.burst_busy = (phase_cur != PH_IDLE);

        phase_next = phase_cur;
        ticks_next = ticks_cur;
        long_next  = long_cur;

        // A duration of zero ends its phase after one tick, like a duration of one.
        if (phase_cur != PH_IDLE)
        begin
            if (ticks_cur > 16'd1)
            begin
                ticks_next = ticks_cur - 1'b1;
            end
            else
            begin
                unique case (phase_cur)
                    PH_HEADER:
                    begin
                        phase_next = PH_GAP;
                        ticks_next = dur.gap;
                    end
                    PH_GAP:
                    begin
                        phase_next = PH_MARK;
                        ticks_next = long_cur ? dur.long_mark : dur.short_mark;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            ticks_reg       <= '0;
            long_reg        <= 1'b0;
            pending_reg     <= 1'b0;
            prev_blue_reg   <= 1'b0;
            prev_yellow_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            ticks_reg       <= ticks_next;
            long_reg        <= long_next;
            pending_reg     <= pending_next;
            prev_blue_reg   <= prev_blue_next;
            prev_yellow_reg <= prev_yellow_next;
        end
    end

endmodule

// ===== sv/button_debounce_ir_pulse_sender_top.sv =====
// ----------------------------------------------------------------------------
// Button debounce and IR pulse sender, top level
// Three debounce lanes feed a burst sequencer; results leave through an
// output register backed by a skid register.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    raw_red, raw_blue, raw_yellow
//   output    out_valid / out_ready  laser_en, ir_enable, burst_busy
//   config    cfg_we                 cfg_index, cfg_data
//
// One carrier tick is accepted per clock while the skid register is empty; its
// result is in the output register on the next cycle unless the output stalls.
// The lane counters and the phase timer are updated in the accepting cycle.
// The skid register holds one result accepted after the output stalls;
// in_ready drops only while the skid register is full.
// Reset restores the register defaults and clears all counters at once.
// ----------------------------------------------------------------------------
module button_debounce_ir_pulse_sender_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              raw_red,
    input  logic                              raw_blue,
    input  logic                              raw_yellow,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              laser_en,
    output logic                              ir_enable,
    output logic                              burst_busy,
    input  logic                              cfg_we,
    input  logic [bdips_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdips_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bdips_pkg::*;

    logic [CNT_W-1:0] threshold_reg;
    dur_cfg_t         dur_reg;

    logic    step;
    logic    take;
    btn_t    pressed;
    result_t result;

    result_t out_data_reg;
    logic    out_valid_reg;
    result_t skid_data_reg;
    logic    skid_valid_reg;

    assign in_ready = ~skid_valid_reg;
    assign step     = in_valid & in_ready;
    assign take     = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THRESHOLD_RST;
            dur_reg.header     <= HEADER_RST;
            dur_reg.gap        <= GAP_RST;
            dur_reg.short_mark <= SHORT_MARK_RST;
            dur_reg.long_mark  <= LONG_MARK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE_THRESHOLD: threshold_reg      <= cfg_data[CNT_W-1:0];
                CFG_HEADER_TICKS:       dur_reg.header     <= cfg_data[TICK_W-1:0];
                CFG_GAP_TICKS:          dur_reg.gap        <= cfg_data[TICK_W-1:0];
                CFG_SHORT_MARK_TICKS:   dur_reg.short_mark <= cfg_data[TICK_W-1:0];
                CFG_LONG_MARK_TICKS:    dur_reg.long_mark  <= cfg_data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    bdips_lane u_lane_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .raw       (raw_red),
        .threshold (threshold_reg),
        .pressed   (pressed.red)
    );

    bdips_lane u_lane_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .raw       (raw_blue),
        .threshold (threshold_reg),
        .pressed   (pressed.blue)
    );

    bdips_lane u_lane_yellow (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .raw       (raw_yellow),
        .threshold (threshold_reg),
        .pressed   (pressed.yellow)
    );

    bdips_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pressed (pressed),
        .dur     (dur_reg),
        .result  (result)
    );

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= step;
            end
        end
        else if (step)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (step)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign laser_en   = out_data_reg.laser_en;
    assign ir_enable  = out_data_reg.ir_enable;
    assign burst_busy = out_data_reg.burst_busy;

endmodule

// ===== test/tb_button_debounce_ir_pulse_sender_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the button debounce and IR pulse sender
// Drives carrier ticks with random button levels through the valid/ready
// input, predicts laser and IR outputs tick by tick, and compares every
// output transaction field by field. Both sides stall at random; timings
// are rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_button_debounce_ir_pulse_sender_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bdips_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_GAP, PH_MARK} burst_phase_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam btn_t BTN_NONE = 3'b000;
    localparam btn_t BTN_RED  = 3'b100;
    localparam btn_t BTN_BLUE = 3'b010;
    localparam btn_t BTN_YEL  = 3'b001;
    localparam btn_t BTN_ALL  = 3'b111;

    localparam int STUCK_LIMIT = 3000;
    localparam int LONG_HOLD   = 80;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  raw_red    = 1'b0;
    logic                  raw_blue   = 1'b0;
    logic                  raw_yellow = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  laser_en;
    logic                  ir_enable;
    logic                  burst_busy;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Shadow of the debounce lanes and the burst sequencer.
    logic [CNT_W-1:0]  thr_cfg   = THRESHOLD_RST;
    logic [TICK_W-1:0] hdr_cfg   = HEADER_RST;
    logic [TICK_W-1:0] gap_cfg   = GAP_RST;
    logic [TICK_W-1:0] short_cfg = SHORT_MARK_RST;
    logic [TICK_W-1:0] long_cfg  = LONG_MARK_RST;

    logic [CNT_W-1:0]  red_cnt    = '0;
    logic [CNT_W-1:0]  blue_cnt   = '0;
    logic [CNT_W-1:0]  yel_cnt    = '0;
    logic              blue_seen  = 1'b0;
    logic              yel_seen   = 1'b0;
    burst_phase_t      burst_ph   = PH_IDLE;
    logic [TICK_W-1:0] ticks_left = '0;
    logic              long_code  = 1'b0;
    logic              yel_queued = 1'b0;

    btn_t    button_ticks_q[$];
    result_t tick_results_q[$];
    btn_t    offered;
    result_t oldest_exp;

    int  pushed_total = 0;
    int  err_cnt      = 0;
    int  send_gap     = 0;
    int  hold_left    = 0;
    int  taken_cnt    = 0;
    int  next_hold_at = 300;
    int  stuck_cycles = 0;
    logic calm        = 1'b0;

    button_debounce_ir_pulse_sender_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_red    (raw_red),
        .raw_blue   (raw_blue),
        .raw_yellow (raw_yellow),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .laser_en   (laser_en),
        .ir_enable  (ir_enable),
        .burst_busy (burst_busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10ns clk = 1'b1;
        #10ns clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] cnt, logic raw);
        if (!raw)
            return '0;
        if (cnt < COUNT_MAX)
            return cnt + CNT_W'(1);
        return cnt;
    endfunction

    function automatic void begin_header(logic is_long);
        burst_ph   = PH_HEADER;
        ticks_left = hdr_cfg;
        long_code  = is_long;
    endfunction

    // One carrier tick: counters first, then a possible burst start, then the
    // outputs from the current phase, and last the phase timer.
    function automatic result_t run_debounce_tick(btn_t b);
        result_t r;
        logic    red_p;
        logic    blue_p;
        logic    yel_p;
        logic    blue_rise;
        logic    yel_rise;
        red_cnt  = sat_count(red_cnt, b.red);
        blue_cnt = sat_count(blue_cnt, b.blue);
        yel_cnt  = sat_count(yel_cnt, b.yellow);
        red_p    = red_cnt > thr_cfg;
        blue_p   = blue_cnt > thr_cfg;
        yel_p    = yel_cnt > thr_cfg;
        if (burst_ph == PH_IDLE)
        begin
            if (yel_queued)
            begin
                // The queued yellow code goes out before any new sampling.
                yel_queued = 1'b0;
                begin_header(1'b1);
            end
            else
            begin
                blue_rise = blue_p && !blue_seen;
                yel_rise  = yel_p && !yel_seen;
                blue_seen = blue_p;
                yel_seen  = yel_p;
                if (blue_rise)
                begin
                    yel_queued = yel_rise;
                    begin_header(1'b0);
                end
                else if (yel_rise)
                    begin_header(1'b1);
            end
        end
        if (burst_ph == PH_IDLE)
        begin
            r.laser_en   = red_p;
            r.ir_enable  = 1'b0;
            r.burst_busy = 1'b0;
            return r;
        end
        r.laser_en   = 1'b0;
        r.ir_enable  = (burst_ph == PH_HEADER) || (burst_ph == PH_MARK);
        r.burst_busy = 1'b1;
        // A duration of zero behaves like one tick.
        if (ticks_left > TICK_W'(1))
            ticks_left = ticks_left - TICK_W'(1);
        else
        begin
            unique case (burst_ph)
                PH_HEADER:
                begin
                    burst_ph   = PH_GAP;
                    ticks_left = gap_cfg;
                end
                PH_GAP:
                begin
                    burst_ph   = PH_MARK;
                    ticks_left = long_code ? long_cfg : short_cfg;
                end
                default:
                begin
                    burst_ph   = PH_IDLE;
                    ticks_left = '0;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0b, got %0b", name, want, got);
            err_cnt++;
        end
    endfunction

    // Driver: offers queued ticks, predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tick_results_q.push_back(run_debounce_tick(offered));
                send_gap = pick_gap();
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (button_ticks_q.size() > 0)
                begin
                    offered = button_ticks_q.pop_front();
                    raw_red    <= offered.red;
                    raw_blue   <= offered.blue;
                    raw_yellow <= offered.yellow;
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off now and then so the
    // input side backs up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                taken_cnt++;
            if (taken_cnt >= next_hold_at)
            begin
                next_hold_at += 700;
                hold_left = LONG_HOLD;
            end
            else if (hold_left == 0)
                hold_left = pick_gap();
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tick_results_q.size() == 0)
            begin
                $error("unexpected output transaction: laser_en=%0b ir_enable=%0b burst_busy=%0b",
                       laser_en, ir_enable, burst_busy);
                err_cnt++;
            end
            else
            begin
                oldest_exp = tick_results_q.pop_front();
                check_field("laser_en", oldest_exp.laser_en, laser_en);
                check_field("ir_enable", oldest_exp.ir_enable, ir_enable);
                check_field("burst_busy", oldest_exp.burst_busy, burst_busy);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic push_ticks(input btn_t b, input int n);
        for (int i = 0; i < n; i++)
        begin
            button_ticks_q.push_back(b);
            pushed_total++;
        end
    endtask

    // Waits until every queued tick is accepted and every result has come out.
    task automatic quiesce();
        @(negedge clk);
        while (button_ticks_q.size() != 0 || in_valid || tick_results_q.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            CFG_DEBOUNCE_THRESHOLD: thr_cfg   = data[CNT_W-1:0];
            CFG_HEADER_TICKS:       hdr_cfg   = data[TICK_W-1:0];
            CFG_GAP_TICKS:          gap_cfg   = data[TICK_W-1:0];
            CFG_SHORT_MARK_TICKS:   short_cfg = data[TICK_W-1:0];
            CFG_LONG_MARK_TICKS:    long_cfg  = data[TICK_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drains the block and lets any running or queued burst finish before
    // new timings go in.
    task automatic set_timing(input logic [CNT_W-1:0] thr, input logic [TICK_W-1:0] hdr,
                              input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] shrt,
                              input logic [TICK_W-1:0] lng);
        quiesce();
        while (burst_ph != PH_IDLE || yel_queued)
        begin
            push_ticks(BTN_NONE, 16);
            quiesce();
        end
        write_reg(CFG_DEBOUNCE_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_HEADER_TICKS, hdr);
        write_reg(CFG_GAP_TICKS, gap);
        write_reg(CFG_SHORT_MARK_TICKS, shrt);
        write_reg(CFG_LONG_MARK_TICKS, lng);
    endtask

    // Mostly presses held past the threshold followed by a release; the rest
    // is noise and presses that let go too early.
    task automatic add_segment(input int thr, input int rel_max);
        int   kind;
        int   len;
        int   lag;
        btn_t hold;
        btn_t b;
        kind = $urandom_range(0, 9);
        hold = 3'($urandom_range(1, 7));
        if (kind < 7)
        begin
            len = thr + 1 + $urandom_range(0, 4);
            lag = $urandom_range(0, 2);
            for (int i = 0; i < len + lag; i++)
            begin
                b = hold;
                if (i < lag)
                    b.yellow = 1'b0;
                if (kind >= 5)
                    b.red = 1'($urandom_range(0, 1));
                push_ticks(b, 1);
            end
            len = $urandom_range(1, rel_max);
            for (int i = 0; i < len; i++)
            begin
                b = BTN_NONE;
                if (kind[0])
                    b.red = 1'($urandom_range(0, 1));
                push_ticks(b, 1);
            end
        end
        else if (kind == 7)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_ticks(3'($urandom_range(0, 7)), 1);
        end
        else
        begin
            push_ticks(hold, $urandom_range(0, thr));
            push_ticks(BTN_NONE, 1);
        end
    endtask

    task automatic fill_random(input int target, input int thr, input int rel_max);
        int base;
        base = pushed_total;
        while (pushed_total - base < target)
            add_segment(thr, rel_max);
    endtask

    initial
    begin
        btn_t b;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timings: short taps never reach the threshold.
        push_ticks(BTN_NONE, 1);
        push_ticks(BTN_ALL, 1);

        // Zero threshold and a zero header, which must last one tick.
        set_timing(8'd0, 16'd0, 16'd1, 16'd2, 16'd1);
        push_ticks(BTN_RED | BTN_YEL, 4);
        push_ticks(BTN_NONE, 2);
        // Blue and yellow edges on the same tick: yellow follows blue.
        push_ticks(BTN_BLUE | BTN_YEL, 1);
        push_ticks(BTN_NONE, 7);
        // A release and re-press during a burst is judged against the old sample.
        push_ticks(BTN_BLUE, 1);
        push_ticks(BTN_NONE, 1);
        push_ticks(BTN_BLUE, 3);
        push_ticks(BTN_NONE, 1);
        quiesce();
        // Writes to unused indexes change nothing.
        write_reg(CFG_UNUSED_LO, 16'hFFFF);
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        push_ticks(BTN_YEL, 1);
        push_ticks(BTN_NONE, 3);

        set_timing(THRESHOLD_RST, HEADER_RST, GAP_RST, SHORT_MARK_RST, LONG_MARK_RST);
        fill_random(250, 100, 60);

        set_timing(8'd3, 16'd4, 16'd2, 16'd3, 16'd6);
        fill_random(120, 3, 12);

        // Minimum timings with no random gaps on either side; the receiver's periodic long hold-off still applies.
        set_timing(8'd0, 16'd1, 16'd1, 16'd1, 16'd1);
        calm = 1'b1;
        fill_random(80, 0, 6);
        quiesce();
        calm = 1'b0;

        // Holds longer than the counter range check saturation.
        set_timing(8'd254, 16'd2, 16'd1, 16'd2, 16'd3);
        push_ticks(BTN_ALL, 264);
        push_ticks(BTN_NONE, 12);

        // Top threshold: nothing ever counts as pressed.
        set_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        fill_random(60, 6, 8);

        // Longest yellow mark configured, but only blue codes are sent.
        set_timing(8'd1, 16'd1, 16'd1, 16'd5, 16'hFFFF);
        for (int i = 0; i < 8; i++)
        begin
            b = BTN_BLUE;
            b.red = 1'($urandom_range(0, 1));
            push_ticks(b, 3);
            push_ticks(BTN_NONE, 9);
        end

        set_timing(8'd7, 16'd2, 16'd3, 16'd1, 16'd2);
        fill_random(80, 7, 20);

        quiesce();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
